### hw/rtl/fcba_pkg.sv
// package: constants, codes and types for the chained block allocator
package fcba_pkg;

  localparam int NumBlocks      = 256;
  localparam int DirEntries     = 16;
  localparam int ReservedBlocks = 13;
  localparam int BlkW           = 8;
  localparam int SlotW          = 4;
  localparam int CntW           = 9;

  typedef logic [BlkW-1:0]  blk_t;
  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    REQ_CREATE = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_NEXT   = 3'd4,
    REQ_FIRST  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXISTS      = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_DIR_FULL    = 3'd3,
    ST_NOT_EMPTY   = 3'd4,
    ST_DISK_FULL   = 3'd5,
    ST_NOT_IN_FILE = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,      // formatting sweep of the table
    S_IDLE,
    S_WALK,      // walk chain, one table read per cycle
    S_APP_HEAD,  // free head link read in flight
    S_APP_FIX,   // write links for append
    S_DEL_NEXT,  // write victim's successor into predecessor link
    S_DEL_FREE,  // link victim block to the old free head
    S_DEL_FIX,
    S_OUT
  } state_t;

  // formatted contents of one table entry
  function automatic blk_t fmt_entry(input logic [CntW-1:0] i);
    blk_t v;
    v = '0;
    if (i == '0) v = blk_t'(ReservedBlocks);
    else if (i >= CntW'(ReservedBlocks) && i < CntW'(NumBlocks - 1)) v = blk_t'(i + 1'b1);
    return v;
  endfunction

endpackage

### hw/rtl/fat_chain_block_allocator.sv
// top level: directory plus allocation table with chain walking sequencer
// operation: create/remove/first are decided at accept and registered for output;
//   append pops the free head and walks to the end of the file's chain, next walks
//   to the block, delete walks to the block and then rewrites links, all through the
//   single-port table memory; one beat at a time
// reset: directory valid bits clear at once; a formatting sweep then writes
//   every table entry in turn, during which in_tready stays low
module fat_chain_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // req_type[2:0], file_name[66:3], block_num[74:67]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[2:0], block_out[10:3]
);

  // table memory
  fcba_pkg::blk_t tab_mem [fcba_pkg::NumBlocks];
  fcba_pkg::blk_t tab_rd_r;
  logic           tab_we;
  fcba_pkg::blk_t tab_addr, tab_wd;

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_addr] <= tab_wd;
    tab_rd_r <= tab_mem[tab_addr];
  end

  // directory
  logic [63:0]    dir_name_r  [fcba_pkg::DirEntries];
  logic [fcba_pkg::DirEntries-1:0] dir_valid_r;
  fcba_pkg::blk_t dir_first_r [fcba_pkg::DirEntries];

  fcba_pkg::state_t state_r, state_nxt;
  logic [fcba_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [2:0]     req_r;
  fcba_pkg::blk_t blk_r;
  fcba_pkg::slot_t slot_r;
  fcba_pkg::blk_t cur_r, cur_nxt, prev_r, prev_nxt, nb_r, nb_nxt, aux_r, aux_nxt;
  logic [2:0]     st_r, st_nxt;
  fcba_pkg::blk_t bo_r, bo_nxt;

  // directory lookup of the incoming name
  logic [63:0]     in_name;
  logic            f_hit, f_free;
  fcba_pkg::slot_t f_slot, f_fslot;
  assign in_name = in_tdata[66:3];
  always_comb begin
    f_hit = 1'b0; f_slot = '0; f_free = 1'b0; f_fslot = '0;
    for (int i = fcba_pkg::DirEntries - 1; i >= 0; i--) begin
      if (dir_valid_r[i] && dir_name_r[i] == in_name) begin
        f_hit = 1'b1; f_slot = fcba_pkg::slot_t'(i);
      end
      if (!dir_valid_r[i]) begin
        f_free = 1'b1; f_fslot = fcba_pkg::slot_t'(i);
      end
    end
  end

  logic acc;
  assign in_tready = (state_r == fcba_pkg::S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = (state_r == fcba_pkg::S_OUT);
  assign out_tdata  = {5'd0, bo_r, st_r};

  fcba_pkg::blk_t first_c;
  assign first_c = dir_first_r[slot_r];

  // status for requests finished at accept
  logic [2:0] st_fast;
  always_comb begin
    st_fast = fcba_pkg::ST_NOT_FOUND;
    case (in_tdata[2:0])
      fcba_pkg::REQ_CREATE: st_fast = f_hit ? fcba_pkg::ST_EXISTS :
                                      (f_free ? fcba_pkg::ST_OK : fcba_pkg::ST_DIR_FULL);
      fcba_pkg::REQ_REMOVE: if (f_hit) st_fast = (dir_first_r[f_slot] != '0) ?
                                      fcba_pkg::ST_NOT_EMPTY : fcba_pkg::ST_OK;
      fcba_pkg::REQ_FIRST:  if (f_hit) st_fast = fcba_pkg::ST_OK;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    cur_nxt = cur_r; prev_nxt = prev_r; nb_nxt = nb_r; aux_nxt = aux_r;
    st_nxt = st_r; bo_nxt = bo_r;
    tab_we = 1'b0; tab_addr = '0; tab_wd = '0;
    unique case (state_r)
      fcba_pkg::S_INIT: begin
        tab_we = 1'b1; tab_addr = cnt_r[fcba_pkg::BlkW-1:0];
        tab_wd = fcba_pkg::fmt_entry(cnt_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fcba_pkg::CntW'(fcba_pkg::NumBlocks - 1))
          state_nxt = fcba_pkg::S_IDLE;
      end
      fcba_pkg::S_IDLE: begin
        if (acc) begin
          st_nxt = st_fast;
          bo_nxt = (f_hit && in_tdata[2:0] == fcba_pkg::REQ_FIRST) ? dir_first_r[f_slot] : '0;
          cur_nxt = dir_first_r[f_slot]; prev_nxt = '0;
          cnt_nxt = '0;
          state_nxt = fcba_pkg::S_OUT;
          if (f_hit) begin
            case (in_tdata[2:0])
              fcba_pkg::REQ_APPEND: state_nxt = fcba_pkg::S_APP_HEAD;
              fcba_pkg::REQ_DELETE, fcba_pkg::REQ_NEXT: begin
                state_nxt = fcba_pkg::S_WALK;
              end
              default: ;
            endcase
          end
          // address for first walk or free head
          tab_addr = (in_tdata[2:0] == fcba_pkg::REQ_APPEND) ? '0 : dir_first_r[f_slot];
        end
      end
      fcba_pkg::S_APP_HEAD: begin
        // tab_rd_r holds free head; fetch its link
        nb_nxt = tab_rd_r; tab_addr = tab_rd_r;
        if (tab_rd_r == '0) begin
          st_nxt = fcba_pkg::ST_DISK_FULL; state_nxt = fcba_pkg::S_OUT;
        end else begin
          state_nxt = fcba_pkg::S_APP_FIX; cnt_nxt = '0;
        end
      end
      fcba_pkg::S_APP_FIX: begin
        // cnt 0: pop free list, 1: clear nb link, then walk to chain end
        if (cnt_r == '0) begin
          tab_we = 1'b1; tab_addr = '0; tab_wd = tab_rd_r; cnt_nxt = 9'd1;
        end else if (cnt_r == 9'd1) begin
          tab_we = 1'b1; tab_addr = nb_r; tab_wd = '0; cnt_nxt = 9'd2;
          st_nxt = fcba_pkg::ST_OK; bo_nxt = nb_r;
          if (first_c == '0) state_nxt = fcba_pkg::S_OUT;
          cur_nxt = first_c;
        end else if (cnt_r == 9'd2) begin
          tab_addr = cur_r; cnt_nxt = 9'd3;
        end else begin
          if (tab_rd_r == '0) begin
            tab_we = 1'b1; tab_addr = cur_r; tab_wd = nb_r;
            state_nxt = fcba_pkg::S_OUT;
          end else begin
            cur_nxt = tab_rd_r; tab_addr = tab_rd_r;
          end
        end
      end
      fcba_pkg::S_WALK: begin
        // cur_r was issued last cycle; tab_rd_r is its link
        if (cur_r == '0 || cnt_r == fcba_pkg::CntW'(fcba_pkg::NumBlocks)) begin
          st_nxt = fcba_pkg::ST_NOT_IN_FILE; state_nxt = fcba_pkg::S_OUT;
        end else if (cur_r == blk_r) begin
          aux_nxt = tab_rd_r;
          if (req_r == fcba_pkg::REQ_NEXT) begin
            st_nxt = fcba_pkg::ST_OK; bo_nxt = tab_rd_r; state_nxt = fcba_pkg::S_OUT;
          end else begin
            tab_addr = '0; state_nxt = fcba_pkg::S_DEL_FREE;
          end
        end else begin
          prev_nxt = cur_r; cur_nxt = tab_rd_r; tab_addr = tab_rd_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fcba_pkg::S_DEL_FREE: begin
        // victim links to old free head; push and unlink follow
        tab_we = 1'b1; tab_addr = blk_r; tab_wd = tab_rd_r;
        state_nxt = fcba_pkg::S_DEL_FIX;
      end
      fcba_pkg::S_DEL_FIX: begin
        tab_we = 1'b1; tab_addr = '0; tab_wd = blk_r;
        if (prev_r != '0) state_nxt = fcba_pkg::S_DEL_NEXT;
        else state_nxt = fcba_pkg::S_OUT;
        st_nxt = fcba_pkg::ST_OK;
      end
      fcba_pkg::S_DEL_NEXT: begin
        tab_we = 1'b1; tab_addr = prev_r; tab_wd = aux_r;
        state_nxt = fcba_pkg::S_OUT;
      end
      fcba_pkg::S_OUT: begin
        if (out_tready) state_nxt = fcba_pkg::S_IDLE;
      end
      default: state_nxt = fcba_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcba_pkg::S_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; prev_r <= prev_nxt; nb_r <= nb_nxt; aux_r <= aux_nxt;
    st_r <= st_nxt; bo_r <= bo_nxt;
    if (acc) begin
      req_r  <= in_tdata[2:0];
      blk_r  <= in_tdata[74:67];
      slot_r <= f_slot;
    end
  end

  // directory updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_valid_r <= '0;
      for (int i = 0; i < fcba_pkg::DirEntries; i++) dir_first_r[i] <= '0;
    end else begin
      if (acc) begin
        unique case (in_tdata[2:0])
          fcba_pkg::REQ_CREATE: begin
            if (!f_hit && f_free) begin
              dir_valid_r[f_fslot] <= 1'b1;
              dir_name_r[f_fslot]  <= in_name;
              dir_first_r[f_fslot] <= '0;
            end
          end
          fcba_pkg::REQ_REMOVE: begin
            if (f_hit && dir_first_r[f_slot] == '0) dir_valid_r[f_slot] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_r == fcba_pkg::S_APP_FIX && cnt_r == 9'd1 && first_c == '0)
        dir_first_r[slot_r] <= nb_r;
      if (state_r == fcba_pkg::S_DEL_FIX && prev_r == '0)
        dir_first_r[slot_r] <= aux_r;
    end
  end

  // assertions
  a_no_out_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcba_pkg::S_INIT |-> !out_tvalid) else $error("out during init");
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready with pending result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out drop");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fcba_pkg::S_WALK |-> cnt_r <= fcba_pkg::CntW'(fcba_pkg::NumBlocks))
    else $error("walk overrun");

endmodule
